@@ src/skbh_pkg.sv @@
package skbh_pkg;

  localparam int unsigned KeyLenW = 9;
  localparam int unsigned MaxKeyLenDefault = 256;
  localparam logic [15:0] TableSizeReset = 16'd64;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw = $clog2(QueueDepth);

  typedef enum logic [1:0] {
    KindSingle,
    KindMid,
    KindLast
  } skbh_kind_e;

  // one queued word from the front to the back
  typedef struct packed {
    skbh_kind_e         kind;
    logic signed [7:0]  byte_val;
    logic [KeyLenW-1:0] pos;
    logic [KeyLenW-1:0] len;
    logic signed [7:0]  nbr;
  } skbh_entry_t;

  // finished hash or raw byte handed to the modulo unit
  typedef struct packed {
    logic        raw;
    logic [31:0] value;
  } skbh_res_t;

  // magnitude mod 3 by folding 2-bit digits, since 4 is 1 mod 3
  function automatic logic is_mult3(logic [7:0] mag);
    logic [3:0] s1;
    logic [2:0] s2;
    s1 = 4'(mag[1:0]) + 4'(mag[3:2]) + 4'(mag[5:4]) + 4'(mag[7:6]);
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]);
    return (s2 == 3'd0) || (s2 == 3'd3) || (s2 == 3'd6);
  endfunction

endpackage

@@ src/skbh_fifo.sv @@
module skbh_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  skbh_pkg::skbh_entry_t data_i,
  input  logic                 pop_i,
  output skbh_pkg::skbh_entry_t data_o,
  output logic                 full_o,
  output logic                 empty_o
);
  import skbh_pkg::*;

  logic [QueueAw:0] wr_q, wr_d, rd_q, rd_d;
  skbh_entry_t      mem_q [QueueDepth];

  assign full_o  = (wr_q[QueueAw] != rd_q[QueueAw]) &&
                   (wr_q[QueueAw-1:0] == rd_q[QueueAw-1:0]);
  assign empty_o = (wr_q == rd_q);
  assign data_o  = mem_q[rd_q[QueueAw-1:0]];

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (push_i) begin
      wr_d = wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q[QueueAw-1:0]] <= data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
`endif

endmodule

@@ src/skbh_front.sv @@
module skbh_front #(
  parameter int unsigned MAX_KEY_LEN = skbh_pkg::MaxKeyLenDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [7:0]             byte_value_i,
  input  logic [skbh_pkg::KeyLenW-1:0]  key_length_i,
  input  logic                          full_i,
  output logic                          push_o,
  output skbh_pkg::skbh_entry_t         entry_o
);
  import skbh_pkg::*;

  localparam int unsigned LenFieldMax = (1 << KeyLenW) - 1;
  localparam int unsigned LenCapInt = (MAX_KEY_LEN > LenFieldMax) ? LenFieldMax : MAX_KEY_LEN;
  localparam logic [KeyLenW-1:0] LenCap = KeyLenW'(LenCapInt);

  logic [KeyLenW-1:0] pos_q, pos_d, len_q, len_d, len_clamp, pos_inc;
  logic signed [7:0]  prev_q, prev_d;

  assign in_ready_o = !full_i;

  always_comb begin
    len_clamp = (key_length_i > LenCap) ? LenCap : key_length_i;
    pos_inc   = pos_q + KeyLenW'(1);
    pos_d     = pos_q;
    len_d     = len_q;
    prev_d    = prev_q;
    push_o    = 1'b0;
    entry_o.byte_val = byte_value_i;
    entry_o.pos      = pos_q;
    entry_o.len      = len_q;
    entry_o.nbr      = (pos_q == KeyLenW'(1)) ? byte_value_i : prev_q;
    entry_o.kind     = (pos_inc == len_q) ? KindLast : KindMid;
    if (in_valid_i && !full_i) begin
      if (pos_q == '0) begin
        // first byte: latch length, ignore zero-length keys
        if (key_length_i != '0) begin
          len_d  = len_clamp;
          prev_d = byte_value_i;
          if (len_clamp == KeyLenW'(1)) begin
            push_o       = 1'b1;
            entry_o.kind = KindSingle;
          end else begin
            pos_d = KeyLenW'(1);
          end
        end
      end else begin
        push_o = 1'b1;
        prev_d = byte_value_i;
        pos_d  = (pos_inc == len_q) ? '0 : pos_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      len_q  <= '0;
      prev_q <= '0;
    end else begin
      pos_q  <= pos_d;
      len_q  <= len_d;
      prev_q <= prev_d;
    end
  end

endmodule

@@ src/skbh_mac.sv @@
module skbh_mac (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  skbh_pkg::skbh_entry_t entry_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output skbh_pkg::skbh_res_t   res_o
);
  import skbh_pkg::*;

  localparam logic StFetch = 1'b0;
  localparam logic StMul   = 1'b1;

  logic        state_q, state_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] sum_q, sum_d, fac_q, fac_d;
  logic        last_q, last_d;
  logic        load;
  logic [31:0] p32, q32, i32, l32, t32, prod;
  logic [7:0]  mag;

  assign prod = sum_q * fac_q;

  always_comb begin
    p32 = {{24{entry_i.byte_val[7]}}, entry_i.byte_val};
    q32 = {{24{entry_i.nbr[7]}}, entry_i.nbr};
    i32 = 32'(entry_i.pos);
    l32 = 32'(entry_i.len);
    mag = entry_i.byte_val[7] ? (8'd0 - entry_i.byte_val) : entry_i.byte_val;
    t32 = !is_mult3(mag) ? (p32 << entry_i.pos[4:0]) : (p32 ^ ~i32);
    sum_d  = acc_q + p32 + ~t32;
    fac_d  = (p32 ^ i32) + (l32 | (i32 + l32 - q32));
    last_d = (entry_i.kind == KindLast);
  end

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    pop_o       = 1'b0;
    load        = 1'b0;
    res_valid_o = 1'b0;
    res_o.raw   = 1'b0;
    res_o.value = prod;
    case (state_q)
      StFetch: begin
        if (!empty_i) begin
          if (entry_i.kind == KindSingle) begin
            res_valid_o = 1'b1;
            res_o.raw   = 1'b1;
            res_o.value = {24'd0, entry_i.byte_val};
            pop_o       = res_ready_i;
          end else begin
            pop_o   = 1'b1;
            load    = 1'b1;
            state_d = StMul;
          end
        end
      end
      StMul: begin
        if (!last_q) begin
          acc_d   = prod;
          state_d = StFetch;
        end else begin
          res_valid_o = 1'b1;
          if (res_ready_i) begin
            acc_d   = '0;
            state_d = StFetch;
          end
        end
      end
      default: state_d = StFetch;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StFetch;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sum_q  <= sum_d;
      fac_q  <= fac_d;
      last_q <= last_d;
    end
  end

endmodule

@@ src/skbh_mod.sv @@
module skbh_mod (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                res_valid_i,
  output logic                res_ready_o,
  input  skbh_pkg::skbh_res_t res_i,
  input  logic [15:0]         table_size_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [15:0]         bucket_index_o
);
  import skbh_pkg::*;

  logic        busy_q, busy_d, fin_q, fin_d, raw_q, raw_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] num_q, num_d;
  logic [15:0] rem_q, rem_d, dvs_q, dvs_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_data_q, out_data_d;
  logic [16:0] rem_sh;
  logic        ge, out_load;
  logic [15:0] rem_nx, result;

  assign res_ready_o    = !busy_q;
  assign out_valid_o    = out_valid_q;
  assign bucket_index_o = out_data_q;

  always_comb begin
    rem_sh   = {rem_q, num_q[31]};
    ge       = (rem_sh >= {1'b0, dvs_q});
    rem_nx   = ge ? 16'(rem_sh - {1'b0, dvs_q}) : rem_sh[15:0];
    out_load = busy_q && fin_q && (!out_valid_q || out_ready_i);
    result   = raw_q ? num_q[15:0] : ((dvs_q == '0) ? '0 : rem_q);

    busy_d = busy_q;
    fin_d  = fin_q;
    raw_d  = raw_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (res_valid_i && !busy_q) begin
      busy_d = 1'b1;
      fin_d  = res_i.raw;
      raw_d  = res_i.raw;
      cnt_d  = '0;
      num_d  = res_i.value;
      rem_d  = '0;
      dvs_d  = table_size_i;
    end else if (busy_q && !fin_q) begin
      // restoring division, one quotient bit per cycle
      num_d = {num_q[30:0], 1'b0};
      rem_d = rem_nx;
      cnt_d = cnt_q + 5'd1;
      fin_d = &cnt_q;
    end else if (out_load) begin
      busy_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = result;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      fin_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      fin_q       <= fin_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q      <= raw_d;
    num_q      <= num_d;
    rem_q      <= rem_d;
    dvs_q      <= dvs_d;
    out_data_q <= out_data_d;
  end

`ifndef SYNTHESIS
  a_div_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !fin_q |=> busy_q) else $error("division dropped");
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && !raw_q && (dvs_q != '0) |=> out_data_q < $past(dvs_q))
    else $error("remainder not below divisor");
  a_raw_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && raw_q |=> out_data_q[15:8] == 8'd0) else $error("raw byte too wide");
`endif

endmodule

@@ src/string_key_bucket_hash_top.sv @@
// string key bucket hash
//
// input channel: in_valid_i/in_ready_o carry one key byte per word with the
// key length, which is read only on the first byte of a key. a zero length
// first byte is dropped. keys longer than MAX_KEY_LEN are cut to it.
// output channel: out_valid_o/out_ready_i carry one bucket index per key.
// config channel: cfg_valid_i/cfg_ready_o writes the table size, always ready.
//
// flow: the multiply-accumulate back end takes each byte after the first
// through its fetch and multiply states; the front keeps the first byte of a
// longer key in a register instead of queueing it, and a one-byte key leaves
// the back end as a raw byte. the final modulo is a 32-step restoring divider
// that raw bytes skip; the next key streams through the queue and accumulator
// meanwhile, and the divider takes a new key once the previous index is loaded.
// reset: table size returns to 64, queue and accumulator clear, no sweep.
// a stalled receiver holds the output word, then the divider, then the
// accumulator; the byte queue fills and in_ready_o drops.
module string_key_bucket_hash_top #(
  parameter int unsigned MAX_KEY_LEN = skbh_pkg::MaxKeyLenDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [7:0]            byte_value_i,
  input  logic [skbh_pkg::KeyLenW-1:0] key_length_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [15:0]                  bucket_index_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [15:0]                  cfg_table_size_i
);
  import skbh_pkg::*;

  logic [15:0] table_size_q, table_size_d;
  skbh_entry_t push_entry, head_entry;
  skbh_res_t   res;
  logic        push, pop, full, empty, res_valid, res_ready;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    table_size_d = table_size_q;
    if (cfg_valid_i) begin
      table_size_d = cfg_table_size_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= TableSizeReset;
    end else begin
      table_size_q <= table_size_d;
    end
  end

  skbh_front #(
    .MAX_KEY_LEN(MAX_KEY_LEN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .byte_value_i (byte_value_i),
    .key_length_i (key_length_i),
    .full_i       (full),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  skbh_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .pop_i   (pop),
    .data_o  (head_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  skbh_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (head_entry),
    .empty_i     (empty),
    .pop_o       (pop),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  skbh_mod u_mod (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .res_valid_i    (res_valid),
    .res_ready_o    (res_ready),
    .res_i          (res),
    .table_size_i   (table_size_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .bucket_index_o (bucket_index_o)
  );

endmodule
